// ===== sv/ic_pkg.sv =====
// shared types and constants of the inversion counter
`default_nettype none
package ic_pkg;

    localparam int unsigned VALUE_W       = 64;
    localparam int unsigned COUNT_W       = 19;
    localparam int unsigned COUNT_MAX     = 524287;
    localparam int unsigned DEF_MAX_ITEMS = 1024;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [COUNT_W-1:0]        t_count;

    // status from the sort engine to the top level
    typedef struct packed {
        logic busy;
        logic done;
    } t_sort_stat;

endpackage
`default_nettype wire

// ===== sv/ic_if.sv =====
// valid/ready channels for elements in and results out
`default_nettype none
interface ic_in_if;
    import ic_pkg::*;
    logic   valid;
    logic   ready;
    t_value value;
    logic   last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface ic_out_if;
    import ic_pkg::*;
    logic   valid;
    logic   ready;
    t_count inversion_count;
    logic   overflowed;

    modport source (output valid, output inversion_count, output overflowed, input ready);
    modport sink   (input valid, input inversion_count, input overflowed, output ready);
endinterface
`default_nettype wire

// ===== sv/ic_ram.sv =====
// element memory: one write port, two registered read ports
`default_nettype none
module ic_ram #(
    parameter int unsigned DEPTH = ic_pkg::DEF_MAX_ITEMS,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_wa,
    input  wire ic_pkg::t_value    i_wd,
    input  wire logic [AW-1:0]     i_ra,
    input  wire logic [AW-1:0]     i_rb,
    output ic_pkg::t_value         o_qa,
    output ic_pkg::t_value         o_qb
);
    import ic_pkg::*;

    t_value r_mem [DEPTH];
    t_value r_qa;
    t_value r_qb;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    // two read ports, registered
    always_ff @(posedge i_clk) begin
        r_qa <= r_mem[i_ra];
        r_qb <= r_mem[i_rb];
    end

    assign o_qa = r_qa;
    assign o_qb = r_qb;
endmodule
`default_nettype wire

// ===== sv/ic_sorter.sv =====
// bottom-up merge sort over two ping-pong memories, counting inversions
`default_nettype none
module ic_sorter #(
    parameter int unsigned MAX_ITEMS = ic_pkg::DEF_MAX_ITEMS,
    parameter int unsigned AW        = $clog2(MAX_ITEMS),
    parameter int unsigned CW        = $clog2(MAX_ITEMS + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [CW-1:0]        i_n,
    input  wire logic                 i_load_we,
    input  wire logic [AW-1:0]        i_load_wa,
    input  wire ic_pkg::t_value       i_load_wd,
    output ic_pkg::t_sort_stat        o_stat,
    output ic_pkg::t_count            o_count
);
    import ic_pkg::*;

    localparam int unsigned WW    = CW + 1;
    localparam int unsigned ACC_W = (2 * CW > 20) ? 2 * CW : 20;

    localparam logic [1:0] P_IDLE  = 2'd0;
    localparam logic [1:0] P_SETUP = 2'd1;
    localparam logic [1:0] P_PRIME = 2'd2;
    localparam logic [1:0] P_MERGE = 2'd3;

    logic [1:0]       r_phase, n_phase;
    logic [CW-1:0]    r_n, n_n;
    logic [WW-1:0]    r_width, n_width;
    logic [WW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_mid, n_mid;
    logic [CW-1:0]    r_hi, n_hi;
    logic [CW-1:0]    r_a, n_a;
    logic [CW-1:0]    r_b, n_b;
    logic [CW-1:0]    r_k, n_k;
    logic             r_par, n_par;
    logic             r_done, n_done;
    logic [ACC_W-1:0] r_acc, n_acc;

    logic [WW-1:0]    n_wide;
    logic [WW-1:0]    rem;
    logic [WW-1:0]    lo_step;
    logic [WW-1:0]    width_dbl;
    logic             a_in;
    logic             b_in;
    logic             take_a;
    logic             merge_we;
    t_value           merge_wd;
    logic [AW-1:0]    rd_a;
    logic [AW-1:0]    rd_b;
    t_value           q0a, q0b, q1a, q1b;
    t_value           qa, qb;

    logic             ram0_we;
    logic [AW-1:0]    ram0_wa;
    t_value           ram0_wd;

    // source data comes from the memory the pass reads
    assign qa = r_par ? q1a : q0a;
    assign qb = r_par ? q1b : q0b;

    assign n_wide    = {1'b0, r_n};
    assign a_in      = r_a < r_mid;
    assign b_in      = r_b < r_hi;
    assign take_a    = !b_in || (a_in && (qa <= qb));
    assign merge_we  = (r_phase == P_MERGE);
    assign merge_wd  = take_a ? qa : qb;
    assign lo_step   = r_lo + (r_width << 1);
    assign width_dbl = r_width << 1;

    // sequencer over passes, runs and merge steps
    always_comb begin
        n_phase = r_phase;
        n_n     = r_n;
        n_width = r_width;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_a     = r_a;
        n_b     = r_b;
        n_k     = r_k;
        n_par   = r_par;
        n_done  = 1'b0;
        n_acc   = r_acc;
        rem     = '0;
        rd_a    = r_a[AW-1:0];
        rd_b    = r_b[AW-1:0];
        unique case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    n_n     = i_n;
                    n_width = WW'(1);
                    n_lo    = '0;
                    n_par   = 1'b0;
                    n_acc   = '0;
                    if (i_n <= CW'(1)) begin
                        n_done = 1'b1;
                    end else begin
                        n_phase = P_SETUP;
                    end
                end
            end
            P_SETUP: begin
                // end of the left run
                rem   = n_wide - r_lo;
                n_mid = (rem > r_width) ? CW'(r_lo + r_width) : r_n;
                n_phase = P_PRIME;
            end
            P_PRIME: begin
                // end of the right run, and first reads of both heads
                rem     = n_wide - {1'b0, r_mid};
                n_hi    = (rem > r_width) ? CW'({1'b0, r_mid} + r_width) : r_n;
                n_a     = r_lo[CW-1:0];
                n_b     = r_mid;
                n_k     = r_lo[CW-1:0];
                rd_a    = r_lo[AW-1:0];
                rd_b    = r_mid[AW-1:0];
                n_phase = P_MERGE;
            end
            P_MERGE: begin
                // one output element per cycle
                if (take_a) begin
                    n_a = r_a + CW'(1);
                end else begin
                    n_b   = r_b + CW'(1);
                    n_acc = r_acc + ACC_W'(r_mid - r_a);
                end
                n_k  = r_k + CW'(1);
                rd_a = n_a[AW-1:0];
                rd_b = n_b[AW-1:0];
                if (n_k == r_hi) begin
                    if (lo_step >= n_wide) begin
                        n_width = width_dbl;
                        n_par   = !r_par;
                        n_lo    = '0;
                        if (width_dbl >= n_wide) begin
                            n_done  = 1'b1;
                            n_phase = P_IDLE;
                        end else begin
                            n_phase = P_SETUP;
                        end
                    end else begin
                        n_lo    = lo_step;
                        n_phase = P_SETUP;
                    end
                end
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_width <= n_width;
        r_lo    <= n_lo;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_a     <= n_a;
        r_b     <= n_b;
        r_k     <= n_k;
        r_par   <= n_par;
        r_acc   <= n_acc;
    end

    // memory 0 takes loads, and merge output on odd passes
    always_comb begin
        if (merge_we && r_par) begin
            ram0_we = 1'b1;
            ram0_wa = r_k[AW-1:0];
            ram0_wd = merge_wd;
        end else begin
            ram0_we = i_load_we;
            ram0_wa = i_load_wa;
            ram0_wd = i_load_wd;
        end
    end

    ic_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_ram0 (
        .i_clk (i_clk),
        .i_we  (ram0_we),
        .i_wa  (ram0_wa),
        .i_wd  (ram0_wd),
        .i_ra  (rd_a),
        .i_rb  (rd_b),
        .o_qa  (q0a),
        .o_qb  (q0b)
    );

    ic_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_ram1 (
        .i_clk (i_clk),
        .i_we  (merge_we && !r_par),
        .i_wa  (r_k[AW-1:0]),
        .i_wd  (merge_wd),
        .i_ra  (rd_a),
        .i_rb  (rd_b),
        .o_qa  (q1a),
        .o_qb  (q1b)
    );

    assign o_stat.busy = (r_phase != P_IDLE);
    assign o_stat.done = r_done;
    assign o_count     = (r_acc > ACC_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                     : r_acc[COUNT_W-1:0];
endmodule
`default_nettype wire

// ===== sv/inversion_counter.sv =====
// inversion counter: loads a sequence, merge-sorts it and reports the inversion count
//
// i_in carries one signed 64-bit element per transfer; last_item closes the
// sequence. Elements are written to memory at one per cycle while i_in.ready
// is high. Elements beyond MAX_ITEMS are dropped and flagged as overflowed.
// After the last transfer the block sorts n stored elements by a bottom-up
// merge over two memories: each pass merges one element per cycle, limited
// by the single write port of the target memory, and each run first
// passes through a setup and a prime state to set its bounds and prime
// the reads; there are ceil(log2 n) passes.
// i_in.ready is low while sorting. The result (count saturated at 524287 and
// the overflow flag) sits in an output register on o_out; a new sequence may
// load while it waits, and a finished sort holds until the register frees.
// Synchronous active-low reset empties the element count, clears the flag and
// the result valid; memory contents are not cleared and need no clearing pass.
`default_nettype none
module inversion_counter #(
    parameter int unsigned MAX_ITEMS = ic_pkg::DEF_MAX_ITEMS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ic_in_if.sink     i_in,
    ic_out_if.source  o_out
);
    import ic_pkg::*;

    localparam int unsigned AW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_SORT = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_start, n_start;
    logic          r_out_valid, n_out_valid;
    t_count        r_out_count, n_out_count;
    logic          r_out_ovf, n_out_ovf;

    logic          in_xfer;
    logic          has_room;
    t_sort_stat    sort_stat;
    t_count        sort_count;

    assign i_in.ready = (r_state == S_LOAD);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign has_room   = r_count < CW'(MAX_ITEMS);

    // load, sort and result control
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_start     = 1'b0;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_count = r_out_count;
        n_out_ovf   = r_out_ovf;
        unique case (r_state)
            S_LOAD: begin
                if (in_xfer) begin
                    if (has_room) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last_item) begin
                        n_start = 1'b1;
                        n_state = S_SORT;
                    end
                end
            end
            S_SORT: begin
                if (sort_stat.done) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!n_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out_count = sort_count;
                    n_out_ovf   = r_ovf;
                    n_count     = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_count <= n_out_count;
        r_out_ovf   <= n_out_ovf;
    end

    ic_sorter #(.MAX_ITEMS(MAX_ITEMS), .AW(AW), .CW(CW)) u_sorter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_n       (r_count),
        .i_load_we (in_xfer && has_room),
        .i_load_wa (r_count[AW-1:0]),
        .i_load_wd (i_in.value),
        .o_stat    (sort_stat),
        .o_count   (sort_count)
    );

    assign o_out.valid           = r_out_valid;
    assign o_out.inversion_count = r_out_count;
    assign o_out.overflowed      = r_out_ovf;
endmodule
`default_nettype wire
